// ===== rtl/aef_pkg.sv =====
// Shared types, constants and command codes of the envelope follower.
`default_nettype none

package aef_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 17;
    localparam int GAIN_W   = 16;
    localparam int COEF_W   = 16;
    localparam int LEVEL_W  = 17;
    localparam int ENV_W    = 20;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier and accumulator widths
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ROOT_W  = 32;

    // Channels that take part; mask bits at or above this count are ignored
    localparam int NUM_CHANNELS = 2;

    // Fixed-point constants
    localparam logic [ENV_W-1:0]   ENV_MAX   = 20'hFFFFF;
    localparam logic [LEVEL_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [PROD_W-1:0]  GAIN_RND  = 37'd1024;
    localparam logic [PROD_W-1:0]  LEVEL_RND = 37'd32768;
    localparam logic [ROOT_W-1:0]  ROOT_BIT0 = 32'h4000_0000;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL    = 3'd5;

    // Register reset values
    localparam logic [GAIN_W-1:0]  GAIN_RST         = 16'd4096;
    localparam logic [COEF_W-1:0]  ATTACK_COEF_RST  = 16'd65262;
    localparam logic [COEF_W-1:0]  RELEASE_COEF_RST = 16'd65521;
    localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST    = 17'd0;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST    = 17'd65536;

    // Detection modes
    localparam logic MODE_PEAK = 1'b0;
    localparam logic MODE_RMS  = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [COEF_W-1:0]  attack_coef;
        logic [COEF_W-1:0]  release_coef;
        logic               detect_mode;
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] max_level;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_A,
        S_SQ_B,
        S_ROOT_INIT,
        S_ROOT,
        S_GAIN,
        S_ENV_SEL,
        S_ENV_A,
        S_ENV_B,
        S_LVL_A,
        S_LVL_B,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_A,
        OP_SQ_B,
        OP_ROOT_INIT,
        OP_ROOT,
        OP_GAIN,
        OP_ENV_SEL,
        OP_ENV_A,
        OP_ENV_B,
        OP_LVL_A,
        OP_LVL_B,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic use_root;
        logic root_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/aef_ctrl.sv =====
// Sequencer of the envelope follower: steps the datapath through one request.
`default_nettype none

module aef_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire aef_pkg::dp_status_t status,
    output aef_pkg::dp_cmd_t         cmd
);
    import aef_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance through the steps and issue one command per cycle
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SQ_A;
                end
            end
            S_SQ_A: begin
                cmd.op     = OP_SQ_A;
                state_next = S_SQ_B;
            end
            S_SQ_B: begin
                cmd.op     = OP_SQ_B;
                state_next = status.use_root ? S_ROOT_INIT : S_GAIN;
            end
            S_ROOT_INIT: begin
                cmd.op     = OP_ROOT_INIT;
                state_next = S_ROOT;
            end
            S_ROOT: begin
                cmd.op = OP_ROOT;
                if (status.root_last) begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN: begin
                cmd.op     = OP_GAIN;
                state_next = S_ENV_SEL;
            end
            S_ENV_SEL: begin
                cmd.op     = OP_ENV_SEL;
                state_next = S_ENV_A;
            end
            S_ENV_A: begin
                cmd.op     = OP_ENV_A;
                state_next = S_ENV_B;
            end
            S_ENV_B: begin
                cmd.op     = OP_ENV_B;
                state_next = S_LVL_A;
            end
            S_LVL_A: begin
                cmd.op     = OP_LVL_A;
                state_next = S_LVL_B;
            end
            S_LVL_B: begin
                cmd.op     = OP_LVL_B;
                state_next = S_OUT;
            end
            S_OUT: begin
                cmd.op = OP_OUT;
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in work");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !status.out_free) |=> state_reg == S_OUT)
        else $error("result step left while output register is full");

    a_root_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROOT && status.root_last) |=> state_reg == S_GAIN)
        else $error("square root did not finish after its last step");
`endif

endmodule

`default_nettype wire

// ===== rtl/aef_dp.sv =====
// Datapath of the envelope follower: detector, square root, smoother, mapper.
`default_nettype none

module aef_dp (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire aef_pkg::cfg_t                          cfg,
    input  wire aef_pkg::dp_cmd_t                       cmd,
    output aef_pkg::dp_status_t                         status,
    input  wire logic signed [aef_pkg::SAMPLE_W-1:0]    s_sample_a,
    input  wire logic signed [aef_pkg::SAMPLE_W-1:0]    s_sample_b,
    input  wire logic [1:0]                             s_channel_mask,
    input  wire logic                                   s_frame_last,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [aef_pkg::ENV_W-1:0]                   m_envelope,
    output logic [aef_pkg::LEVEL_W-1:0]                 m_level,
    output logic                                        m_block_end
);
    import aef_pkg::*;

    // Captured request
    logic [SAMPLE_W-1:0] samp_a_reg;
    logic [SAMPLE_W-1:0] samp_b_reg;
    logic [1:0]          mask_reg;
    logic                last_reg;

    // Working registers
    logic [PROD_W-1:0]  acc_reg;
    logic [ROOT_W-1:0]  root_v_reg;
    logic [ROOT_W-1:0]  root_res_reg;
    logic [ROOT_W-1:0]  root_bit_reg;
    logic [ENV_W-1:0]   instant_reg;
    logic [COEF_W-1:0]  coef_reg;
    logic [ENV_W-1:0]   env_reg;

    // Output register
    logic               m_valid_reg;
    logic [ENV_W-1:0]   m_envelope_reg;
    logic [LEVEL_W-1:0] m_level_reg;
    logic               m_block_end_reg;

    logic               en_a;
    logic               en_b;
    logic [MAG_W-1:0]   mag_a;
    logic [MAG_W-1:0]   mag_b;
    logic [MAG_W-1:0]   peak;
    logic [MAG_W-1:0]   inst_q15;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  mac;
    logic [ROOT_W-1:0]  root_trial;
    logic [PROD_W-1:0]  gain_rnd;
    logic [PROD_W-12:0] gain_scaled;
    logic [ENV_W-1:0]   instant_next;
    logic [LEVEL_W-1:0] env_clip;
    logic [PROD_W-1:0]  lvl_rnd;
    logic [LEVEL_W-1:0] level_next;
    logic               out_free;

    function automatic logic s_mask_bit(input logic [1:0] m, input int c);
        s_mask_bit = m[c] && (c < NUM_CHANNELS);
    endfunction

    // Channel enables and sample magnitudes
    assign en_a  = s_mask_bit(mask_reg, 0);
    assign en_b  = s_mask_bit(mask_reg, 1);
    assign mag_a = samp_a_reg[SAMPLE_W-1] ? MAG_W'(-{1'b1, samp_a_reg})
                                          : {1'b0, samp_a_reg};
    assign mag_b = samp_b_reg[SAMPLE_W-1] ? MAG_W'(-{1'b1, samp_b_reg})
                                          : {1'b0, samp_b_reg};

    // Peak of present channels and the instant level in Q1.15
    always_comb begin
        peak = '0;
        if (en_a) begin
            peak = mag_a;
        end
        if (en_b && mag_b > peak) begin
            peak = mag_b;
        end
        if (!en_a && !en_b) begin
            inst_q15 = '0;
        end else if (cfg.detect_mode == MODE_PEAK) begin
            inst_q15 = peak;
        end else begin
            inst_q15 = root_res_reg[MAG_W-1:0];
        end
    end

    assign env_clip = (env_reg > ENV_W'(ONE_Q16)) ? ONE_Q16 : env_reg[LEVEL_W-1:0];

    // Select the operands of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ_A: begin
                mul_a = en_a ? MUL_A_W'(mag_a) : '0;
                mul_b = mag_a;
            end
            OP_SQ_B: begin
                mul_a = en_b ? MUL_A_W'(mag_b) : '0;
                mul_b = mag_b;
            end
            OP_GAIN: begin
                mul_a = MUL_A_W'(inst_q15);
                mul_b = MUL_B_W'(cfg.gain);
            end
            OP_ENV_A: begin
                mul_a = instant_reg;
                mul_b = ONE_Q16 - MUL_B_W'(coef_reg);
            end
            OP_ENV_B: begin
                mul_a = env_reg;
                mul_b = MUL_B_W'(coef_reg);
            end
            OP_LVL_A: begin
                mul_a = MUL_A_W'(cfg.min_level);
                mul_b = ONE_Q16 - env_clip;
            end
            OP_LVL_B: begin
                mul_a = MUL_A_W'(cfg.max_level);
                mul_b = env_clip;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign mac  = acc_reg + prod;

    // Square root step, one result bit per cycle
    assign root_trial = root_res_reg + root_bit_reg;

    // Gain scaling with round half up and saturation to Q4.16
    assign gain_rnd     = prod + GAIN_RND;
    assign gain_scaled  = gain_rnd[PROD_W-1:11];
    assign instant_next = (gain_scaled > (PROD_W-11)'(ENV_MAX)) ? ENV_MAX
                                                               : gain_scaled[ENV_W-1:0];

    // Level mapping with round half up and clamp to 1.0
    assign lvl_rnd    = acc_reg + LEVEL_RND;
    assign level_next = (lvl_rnd[PROD_W-1:16] > (PROD_W-16)'(ONE_Q16)) ? ONE_Q16
                                                                        : lvl_rnd[32:16];

    assign out_free = !m_valid_reg || m_ready;

    assign status.use_root  = (cfg.detect_mode == MODE_RMS) && (en_a || en_b);
    assign status.root_last = root_bit_reg[0];
    assign status.out_free  = out_free;

    // Work registers: act on the current command
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                samp_a_reg <= s_sample_a;
                samp_b_reg <= s_sample_b;
                mask_reg   <= s_channel_mask;
                last_reg   <= s_frame_last;
            end
            OP_SQ_A: begin
                acc_reg <= prod;
            end
            OP_SQ_B: begin
                acc_reg <= mac;
            end
            OP_ROOT_INIT: begin
                root_v_reg   <= (en_a && en_b) ? {1'b0, acc_reg[ROOT_W-1:1]}
                                               : acc_reg[ROOT_W-1:0];
                root_res_reg <= '0;
                root_bit_reg <= ROOT_BIT0;
            end
            OP_ROOT: begin
                if (root_v_reg >= root_trial) begin
                    root_v_reg   <= root_v_reg - root_trial;
                    root_res_reg <= (root_res_reg >> 1) + root_bit_reg;
                end else begin
                    root_res_reg <= root_res_reg >> 1;
                end
                root_bit_reg <= root_bit_reg >> 2;
            end
            OP_GAIN: begin
                instant_reg <= instant_next;
            end
            OP_ENV_SEL: begin
                coef_reg <= (instant_reg > env_reg) ? cfg.attack_coef : cfg.release_coef;
            end
            OP_ENV_A: begin
                acc_reg <= prod;
            end
            OP_LVL_A: begin
                acc_reg <= prod;
            end
            OP_LVL_B: begin
                acc_reg <= mac;
            end
            default: begin
            end
        endcase
    end

    // Envelope state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg <= '0;
        end else if (cmd.op == OP_ENV_B) begin
            env_reg <= mac[35:16];
        end
    end

    // Output register: load the result, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT && out_free) begin
            m_envelope_reg  <= env_reg;
            m_level_reg     <= level_next;
            m_block_end_reg <= last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_envelope  = m_envelope_reg;
    assign m_level     = m_level_reg;
    assign m_block_end = m_block_end_reg;

`ifndef NO_ASSERTIONS
    a_env_between: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_ENV_B) |=>
            (env_reg <= $past(instant_reg)) || (env_reg <= $past(env_reg)))
        else $error("envelope moved past both old value and instant level");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_level_reg <= ONE_Q16))
        else $error("control level above 1.0");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT && out_free) |=>
            (m_valid_reg && m_envelope_reg == $past(env_reg)))
        else $error("result register not loaded with the envelope");
`endif

endmodule

`default_nettype wire

// ===== rtl/audio_envelope_follower_core.sv =====
// Top level of the envelope follower: configuration registers, sequencer, datapath.
//
// Usage: the s_ channel takes one audio frame per request (two Q1.15 samples,
// a channel mask and a last-frame flag) under valid/ready. The m_ channel
// returns one result per frame: the Q4.16 envelope, the mapped Q1.16 control
// level and a copy of the last-frame flag. The cfg_ port writes one register
// per cycle while cfg_wr_en is high (0 gain, 1 attack, 2 release, 3 mode,
// 4 min level, 5 max level); other indexes are ignored.
// Timing: a request runs through a shared multiplier one step per cycle,
// but the result step waits while the result register is full. RMS mode
// adds the bit-serial square root between the squaring steps and the gain
// step; peak mode skips it. The next frame is taken only once the sequencer
// is back in idle after loading the result, so a frame is worked through
// to the result register before the next is accepted. A stalled receiver
// holds the result register; the next frame can still be taken and worked
// through, then waits for the register to free. Reset clears the envelope
// to zero, loads the register defaults and empties the result register.
`default_nettype none

module audio_envelope_follower_core (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [aef_pkg::SAMPLE_W-1:0]    s_sample_a,
    input  wire logic signed [aef_pkg::SAMPLE_W-1:0]    s_sample_b,
    input  wire logic [1:0]                             s_channel_mask,
    input  wire logic                                   s_frame_last,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [aef_pkg::ENV_W-1:0]                   m_envelope,
    output logic [aef_pkg::LEVEL_W-1:0]                 m_level,
    output logic                                        m_block_end,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [aef_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [aef_pkg::CFG_W-1:0]              cfg_data
);
    import aef_pkg::*;

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain         <= GAIN_RST;
            cfg_reg.attack_coef  <= ATTACK_COEF_RST;
            cfg_reg.release_coef <= RELEASE_COEF_RST;
            cfg_reg.detect_mode  <= MODE_PEAK;
            cfg_reg.min_level    <= MIN_LEVEL_RST;
            cfg_reg.max_level    <= MAX_LEVEL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GAIN:         cfg_reg.gain         <= cfg_data[GAIN_W-1:0];
                CFG_ATTACK_COEF:  cfg_reg.attack_coef  <= cfg_data[COEF_W-1:0];
                CFG_RELEASE_COEF: cfg_reg.release_coef <= cfg_data[COEF_W-1:0];
                CFG_DETECT_MODE:  cfg_reg.detect_mode  <= cfg_data[0];
                CFG_MIN_LEVEL:    cfg_reg.min_level    <= cfg_data[LEVEL_W-1:0];
                CFG_MAX_LEVEL:    cfg_reg.max_level    <= cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    aef_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    aef_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .status         (status),
        .s_sample_a     (s_sample_a),
        .s_sample_b     (s_sample_b),
        .s_channel_mask (s_channel_mask),
        .s_frame_last   (s_frame_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_envelope     (m_envelope),
        .m_level        (m_level),
        .m_block_end    (m_block_end)
    );

endmodule

`default_nettype wire
